// ===== hw/rtl/avsn_pkg.sv =====
package avsn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] MIN_LENGTH_SQ_RESET = 32'd4295;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } avsn_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
  } avsn_out_t;

  // Side data that rides along with each beat through the pipeline.
  typedef struct packed {
    logic               valid;
    logic               normal;
    logic               degen;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } avsn_side_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ===== hw/rtl/axis_swap_vector_normalize.sv =====
// Channel   Direction  Payload
// in        input      avsn_in_t   (mode, in_x, in_y, in_z)
// out       output     avsn_out_t  (out_x, out_y, out_z, degenerate)
// cfg       input      32-bit min_length_sq, always ready
//
// One beat enters per cycle while the pipeline is not held. A beat passes
// through the reorder, square and sum stages, the one-bit-per-stage square
// root and the one-bit-per-stage dividers, then the output register.
// rst is synchronous; it clears the stage valid bits and sets the threshold to 4295.
// When the output register holds a beat that is not taken, the whole pipeline
// holds; nothing is dropped or repeated.
module axis_swap_vector_normalize #(
  parameter int FRAC_BITS = avsn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  avsn_pkg::avsn_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output avsn_pkg::avsn_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import avsn_pkg::*;

  logic        en;
  logic [31:0] min_length_sq;

  avsn_side_t  s0, s1, s2, s_sq, s_dv;
  logic [31:0] m0 [3];
  logic [63:0] sq [3];
  logic [63:0] lsq;
  logic [31:0] root;
  logic [FRAC_BITS:0] q [3];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_sq <= MIN_LENGTH_SQ_RESET;
    end else if (cfg_valid) begin
      min_length_sq <= cfg_data;
    end
  end

  // Stage 0: reorder to (x, -z, y); negating the most negative z saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (en) begin
      s0.valid <= in_valid;
    end
    if (en) begin
      s0.normal <= in_data.mode;
      s0.degen  <= 1'b0;
      s0.vx     <= in_data.in_x;
      s0.vy     <= (in_data.in_z == NEG_MIN) ? POS_MAX : -in_data.in_z;
      s0.vz     <= in_data.in_y;
    end
  end

  assign m0[0] = mag32(s0.vx);
  assign m0[1] = mag32(s0.vy);
  assign m0[2] = mag32(s0.vz);

  // Stage 1: squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= s0.valid;
    end
    if (en) begin
      s1.normal <= s0.normal;
      s1.degen  <= 1'b0;
      s1.vx     <= s0.vx;
      s1.vy     <= s0.vy;
      s1.vz     <= s0.vz;
      sq[0]     <= 64'(m0[0]) * 64'(m0[0]);
      sq[1]     <= 64'(m0[1]) * 64'(m0[1]);
      sq[2]     <= 64'(m0[2]) * 64'(m0[2]);
    end
  end

  // Stage 2: squared length and threshold test. The sum cannot overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s1.valid;
    end
    if (en) begin
      s2.normal <= s1.normal;
      s2.degen  <= (sq[0] + sq[1] + sq[2]) <= {32'b0, min_length_sq};
      s2.vx     <= s1.vx;
      s2.vy     <= s1.vy;
      s2.vz     <= s1.vz;
      lsq       <= sq[0] + sq[1] + sq[2];
    end
  end

  avsn_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .side_i (s2),
    .n_i    (lsq),
    .side_o (s_sq),
    .root_o (root)
  );

  avsn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .side_i (s_sq),
    .len_i  (root),
    .side_o (s_dv),
    .q_o    (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_dv.valid;
    end
    if (en) begin
      if (!s_dv.normal) begin
        out_data <= {s_dv.vx, s_dv.vy, s_dv.vz, 1'b0};
      end else if (s_dv.degen) begin
        out_data <= {32'sd0, 32'sd0, 32'sd0, 1'b1};
      end else begin
        out_data.out_x      <= s_dv.vx[31] ? -32'(q[0]) : 32'(q[0]);
        out_data.out_y      <= s_dv.vy[31] ? -32'(q[1]) : 32'(q[1]);
        out_data.out_z      <= s_dv.vz[31] ? -32'(q[2]) : 32'(q[2]);
        out_data.degenerate <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/avsn_isqrt.sv =====
module avsn_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  avsn_pkg::avsn_side_t side_i,
  input  logic [63:0]         n_i,
  output avsn_pkg::avsn_side_t side_o,
  output logic [31:0]         root_o
);
  import avsn_pkg::*;

  localparam int STAGES = 32;

  avsn_side_t  side [STAGES+1];
  logic [63:0] n    [STAGES+1];
  logic [32:0] rem  [STAGES+1];
  logic [31:0] root [STAGES+1];

  assign side[0] = side_i;
  assign n[0]    = n_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar i = 1; i <= STAGES; i++) begin : g_stage
    logic [34:0] t;
    logic [34:0] trial;
    logic        take;

    always_comb begin
      t     = {rem[i-1], n[i-1][63:62]};
      trial = {1'b0, root[i-1], 2'b01};
      take  = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[i].valid <= 1'b0;
      end else if (en) begin
        side[i].valid <= side[i-1].valid;
      end
      if (en) begin
        side[i].normal <= side[i-1].normal;
        side[i].degen  <= side[i-1].degen;
        side[i].vx     <= side[i-1].vx;
        side[i].vy     <= side[i-1].vy;
        side[i].vz     <= side[i-1].vz;
        n[i]           <= {n[i-1][61:0], 2'b00};
        rem[i]         <= take ? 33'(t - trial) : 33'(t);
        root[i]        <= {root[i-1][30:0], take};
      end
    end
  end

  assign side_o = side[STAGES];
  assign root_o = root[STAGES];

endmodule

// ===== hw/rtl/avsn_div.sv =====
module avsn_div #(
  parameter int FRAC_BITS = avsn_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  avsn_pkg::avsn_side_t side_i,
  input  logic [31:0]          len_i,
  output avsn_pkg::avsn_side_t side_o,
  output logic [FRAC_BITS:0]   q_o [3]
);
  import avsn_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 32 + QW;

  avsn_side_t  side [QW+1];
  logic [31:0] len  [QW+1];
  logic [31:0] rem  [3][QW+1];
  logic [QW-1:0] lo [3][QW+1];
  logic [QW-1:0] q  [3][QW+1];

  logic [31:0] mag [3];
  assign mag[0] = mag32(side_i.vx);
  assign mag[1] = mag32(side_i.vy);
  assign mag[2] = mag32(side_i.vz);

  assign side[0] = side_i;
  assign len[0]  = len_i;

  // Rounding is folded into the dividend by adding half the divisor.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DW-1:0] dvd;
    assign dvd       = (DW'(mag[l]) << FRAC_BITS) + DW'(len_i >> 1);
    assign rem[l][0] = dvd[DW-1:QW];
    assign lo[l][0]  = dvd[QW-1:0];
    assign q[l][0]   = '0;

    for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [32:0] t;
      logic        take;
      always_comb begin
        t    = {rem[l][i-1], lo[l][i-1][QW-1]};
        take = (t >= {1'b0, len[i-1]});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][i] <= take ? 32'(t - {1'b0, len[i-1]}) : 32'(t);
          lo[l][i]  <= {lo[l][i-1][QW-2:0], 1'b0};
          q[l][i]   <= {q[l][i-1][QW-2:0], take};
        end
      end
    end

    assign q_o[l] = q[l][QW];
  end

  for (genvar i = 1; i <= QW; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i].valid <= 1'b0;
      end else if (en) begin
        side[i].valid <= side[i-1].valid;
      end
      if (en) begin
        side[i].normal <= side[i-1].normal;
        side[i].degen  <= side[i-1].degen;
        side[i].vx     <= side[i-1].vx;
        side[i].vy     <= side[i-1].vy;
        side[i].vz     <= side[i-1].vz;
        len[i]         <= len[i-1];
      end
    end
  end

  assign side_o = side[QW];

endmodule
